### hdl/tssd_pkg.sv
// Shared types, constants and helpers for the TLS session strip detector.
package tssd_pkg;

  localparam int TableEntries = 16;
  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  localparam logic [15:0] LifetimeReset = 16'd60;
  localparam logic [15:0] WindowReset   = 16'd30;

  localparam logic [0:0] CfgLifetime = 1'b0;
  localparam logic [0:0] CfgWindow   = 1'b1;

  localparam logic [1:0] AlertNone  = 2'd0;
  localparam logic [1:0] AlertStrip = 2'd1;
  localparam logic [1:0] AlertWeak  = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [31:0] cli_addr;
    logic [31:0] srv_addr;
    logic [31:0] now_seconds;
    logic [15:0] hello_version;
    logic [15:0] cipher_suite;
    logic        suite_present;
    logic        first_suite;
    logic        last_suite;
    logic        reply_plaintext;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  alert_kind;
    logic [31:0] alert_client;
    logic [31:0] alert_server;
    logic [15:0] alert_version;
  } out_item_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic        is_resp;
    logic        do_store;
    logic        weak_mark;
    logic        plain;
    logic [31:0] cli_addr;
    logic [31:0] srv_addr;
    logic [31:0] now_seconds;
    logic [15:0] version;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } back_state_t;

  function automatic logic suite_is_weak(input logic [15:0] s);
    return (s == 16'h0001) || (s == 16'h0002) || (s == 16'h0003) ||
           (s == 16'h0004) || (s == 16'h0005) || (s == 16'h000a);
  endfunction

endpackage

### hdl/tssd_front.sv
// Front end: accepts items, tracks the ClientHello being built, emits commands.
module tssd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tssd_pkg::in_item_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output tssd_pkg::cmd_t     cmd_data
);

  logic build_active_r, build_active_nxt;
  logic build_weak_r, build_weak_nxt;
  logic act, weak_now, acc;

  assign in_ready = cmd_ready;
  assign acc = in_valid && in_ready;

  always_comb begin
    act = build_active_r || in_data.first_suite;
    weak_now = (in_data.first_suite ? 1'b0 : build_weak_r) ||
               (in_data.suite_present && tssd_pkg::suite_is_weak(in_data.cipher_suite));
    build_active_nxt = build_active_r;
    build_weak_nxt = build_weak_r;
    if (acc && !in_data.mode) begin
      if (act && !in_data.last_suite) begin
        build_active_nxt = 1'b1;
        build_weak_nxt = weak_now;
      end else begin
        build_active_nxt = 1'b0;
        build_weak_nxt = 1'b0;
      end
    end
  end

  // Every item goes to the back end: each one purges.
  assign cmd_valid = in_valid;
  always_comb begin
    cmd_data.is_resp     = in_data.mode;
    cmd_data.do_store    = !in_data.mode && act && in_data.last_suite;
    cmd_data.weak_mark   = weak_now;
    cmd_data.plain       = in_data.reply_plaintext;
    cmd_data.cli_addr    = in_data.cli_addr;
    cmd_data.srv_addr    = in_data.srv_addr;
    cmd_data.now_seconds = in_data.now_seconds;
    cmd_data.version     = in_data.hello_version;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      build_active_r <= 1'b0;
      build_weak_r <= 1'b0;
    end else begin
      build_active_r <= build_active_nxt;
      build_weak_r <= build_weak_nxt;
    end
  end

endmodule

### hdl/tssd_queue.sv
// Two-entry command queue between front and back.
module tssd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  tssd_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output tssd_pkg::cmd_t rd_data
);

  tssd_pkg::cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr_go, rd_go;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr_go = wr_valid && wr_ready;
  assign rd_go = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_go) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_go) wp_r <= !wp_r;
      if (rd_go) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_go} - {1'b0, rd_go};
    end
  end

endmodule

### hdl/tssd_back.sv
// Back end: sweeps the session table one entry a cycle for purge, match and victim.
module tssd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        lifetime,
  input  logic [15:0]        window,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  tssd_pkg::cmd_t     cmd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tssd_pkg::out_item_t out_data
);

  localparam int N = tssd_pkg::TableEntries;
  localparam int IW = tssd_pkg::IdxW;

  logic [N-1:0]  valid_r, valid_nxt;
  logic [63:0]   key_mem [N];
  logic [31:0]   time_mem [N];
  logic [15:0]   ver_mem [N];
  logic          weak_mem [N];
  logic [63:0]   key_rd_r;
  logic [31:0]   time_rd_r;
  logic [15:0]   ver_rd_r;
  logic          weak_rd_r;

  tssd_pkg::back_state_t state_r, state_nxt;
  tssd_pkg::cmd_t cmd_r, cmd_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic          free_r, free_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic [31:0]   best_age_r, best_age_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [15:0]   ver_r, ver_nxt;
  logic          ov_r, ov_nxt;
  tssd_pkg::out_item_t od_r, od_nxt;

  logic [31:0] age;
  logic        alive, match, wr_en, last_idx;
  logic [IW-1:0] wr_idx;

  assign age = cmd_r.now_seconds - time_rd_r;
  assign alive = valid_r[idx_r] && (age <= {16'd0, lifetime});
  assign match = alive && (key_rd_r == {cmd_r.cli_addr, cmd_r.srv_addr});
  assign last_idx = idx_r == IW'(N - 1);
  assign cmd_ready = state_r == tssd_pkg::ST_IDLE;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    free_nxt = free_r;
    free_idx_nxt = free_idx_r;
    best_age_nxt = best_age_r;
    best_idx_nxt = best_idx_r;
    kind_nxt = kind_r;
    ver_nxt = ver_r;
    valid_nxt = valid_r;
    ov_nxt = ov_r && !out_ready;
    od_nxt = od_r;
    wr_en = 1'b0;
    wr_idx = hit_idx_r;
    unique case (state_r)
      tssd_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd_data;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          free_nxt = 1'b0;
          best_age_nxt = '0;
          best_idx_nxt = '0;
          kind_nxt = tssd_pkg::AlertNone;
          ver_nxt = '0;
          state_nxt = tssd_pkg::ST_SWEEP;
        end
      end
      tssd_pkg::ST_SWEEP: begin
        if (!alive) valid_nxt[idx_r] = 1'b0;
        if (match && !hit_r) begin
          hit_nxt = 1'b1;
          hit_idx_nxt = idx_r;
          if (cmd_r.is_resp) begin
            valid_nxt[idx_r] = 1'b0;
            ver_nxt = ver_rd_r;
            if (age <= {16'd0, window}) begin
              if (cmd_r.plain) kind_nxt = tssd_pkg::AlertStrip;
              else if (weak_rd_r) kind_nxt = tssd_pkg::AlertWeak;
            end
          end
        end
        if (!alive && !free_r) begin
          free_nxt = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (idx_r == '0 || age > best_age_r) begin
          best_age_nxt = age;
          best_idx_nxt = idx_r;
        end
        if (last_idx) state_nxt = tssd_pkg::ST_DONE;
        else idx_nxt = idx_r + IW'(1);
      end
      tssd_pkg::ST_DONE: begin
        if (cmd_r.is_resp) begin
          if (!ov_nxt) begin
            ov_nxt = 1'b1;
            od_nxt.alert_kind = kind_r;
            od_nxt.alert_client = cmd_r.cli_addr;
            od_nxt.alert_server = cmd_r.srv_addr;
            od_nxt.alert_version = ver_r;
            state_nxt = tssd_pkg::ST_IDLE;
          end
        end else begin
          if (cmd_r.do_store) begin
            wr_en = 1'b1;
            wr_idx = hit_r ? hit_idx_r : (free_r ? free_idx_r : best_idx_r);
            valid_nxt[wr_idx] = 1'b1;
          end
          state_nxt = tssd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tssd_pkg::ST_IDLE;
    endcase
  end

  // Fetch the entry the sweep visits next so its data is registered on arrival.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx]  <= {cmd_r.cli_addr, cmd_r.srv_addr};
      time_mem[wr_idx] <= cmd_r.now_seconds;
      ver_mem[wr_idx]  <= cmd_r.version;
      weak_mem[wr_idx] <= cmd_r.weak_mark;
    end
    key_rd_r  <= key_mem[idx_nxt];
    time_rd_r <= time_mem[idx_nxt];
    ver_rd_r  <= ver_mem[idx_nxt];
    weak_rd_r <= weak_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    free_r <= free_nxt;
    free_idx_r <= free_idx_nxt;
    best_age_r <= best_age_nxt;
    best_idx_r <= best_idx_nxt;
    kind_r <= kind_nxt;
    ver_r <= ver_nxt;
    od_r <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tssd_pkg::ST_IDLE;
      valid_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

### hdl/tls_session_strip_detector_top.sv
// Top level of the TLS session strip detector.
//   channel | direction | payload
//   in_     | input     | in_item_t, one ClientHello suite or one response
//   out_    | output    | out_item_t, one result per response
//   cfg_    | input     | index 0 lifetime, 1 window, 16-bit data
// The back end finishes each item before taking the next: load, a sweep of one
// entry per cycle for purge, match and oldest-entry search, then store or result.
// The front end classifies combinationally; a two-entry queue decouples it.
// Reset clears the table valid bits, the hello tracker and the control registers.
// A held result stalls the back end; the queue then fills and drops in_ready.
// cfg is always ready.
module tls_session_strip_detector_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tssd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tssd_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0] lifetime_r, window_r;
  logic f_valid, f_ready, q_valid, q_ready;
  tssd_pkg::cmd_t f_data, q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= tssd_pkg::LifetimeReset;
      window_r <= tssd_pkg::WindowReset;
    end else if (cfg_valid && cfg_index[7:1] == 7'd0) begin
      if (cfg_index[0] == tssd_pkg::CfgLifetime) lifetime_r <= cfg_data;
      else window_r <= cfg_data;
    end
  end

  tssd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
  );

  tssd_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  tssd_back u_back (
    .clk, .rst_n, .lifetime(lifetime_r), .window(window_r),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
    .out_valid, .out_ready, .out_data
  );

endmodule
